// ----- design/sks_pkg.sv -----
// shared types, codes and kernel tables for the saturating kernel splatter
package sks_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_PICTURE_WIDTH = 2'd0;
  localparam logic [1:0] CFG_PICTURE_ROWS  = 2'd1;
  localparam logic [1:0] CFG_LARGE_KERNEL  = 2'd2;

  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [9:0] RST_PICTURE_WIDTH = 10'd78;
  localparam logic [8:0] RST_PICTURE_ROWS  = 9'd78;
  localparam logic       RST_LARGE_KERNEL  = 1'b0;

  localparam logic [7:0] LEVEL_MAX = 8'd255;

  localparam logic [2:0] KMAX_SMALL = 3'd2;
  localparam logic [2:0] KMAX_LARGE = 3'd6;
  localparam logic [3:0] RADIUS_SMALL = 4'd1;
  localparam logic [3:0] RADIUS_LARGE = 4'd3;

  localparam logic [3:0] KERN3 [0:2][0:2] = '{
    '{4'd2, 4'd3,  4'd2},
    '{4'd3, 4'd12, 4'd3},
    '{4'd2, 4'd3,  4'd2}
  };

  localparam logic [3:0] KERN7 [0:6][0:6] = '{
    '{4'd0, 4'd1, 4'd1, 4'd2,  4'd1, 4'd1, 4'd0},
    '{4'd1, 4'd1, 4'd2, 4'd3,  4'd2, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd4, 4'd6,  4'd4, 4'd2, 4'd1},
    '{4'd2, 4'd3, 4'd6, 4'd12, 4'd6, 4'd3, 4'd2},
    '{4'd1, 4'd2, 4'd4, 4'd6,  4'd4, 4'd2, 4'd1},
    '{4'd1, 4'd1, 4'd2, 4'd3,  4'd2, 4'd1, 4'd1},
    '{4'd0, 4'd1, 4'd1, 4'd2,  4'd1, 4'd1, 4'd0}
  };

  typedef struct packed {
    logic [9:0] picture_width;
    logic [8:0] picture_rows;
    logic       large_kernel;
  } sks_cfg_t;

  typedef struct packed {
    logic clear;   // write zero at the sweep address
    logic load;    // capture the centre, rewind the kernel walk
    logic step;    // visit one kernel position
    logic finish;  // hand out the held word as the last one
  } sks_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic scan_last;
  } sks_sts_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_FINISH
  } sks_state_t;

  function automatic logic [3:0] kern_weight(input logic sel_large, input logic [2:0] ky,
                                             input logic [2:0] kx);
    logic [3:0] w;
    w = 4'd0;
    if (sel_large) begin
      if (ky < 3'd7 && kx < 3'd7) begin
        w = KERN7[ky][kx];
      end
    end else if (ky < 3'd3 && kx < 3'd3) begin
      w = KERN3[ky[1:0]][kx[1:0]];
    end
    return w;
  endfunction

endpackage

// ----- design/saturating_kernel_splatter_core.sv -----
// top level of the saturating kernel splatter: config registers, controller, datapath
//
// usage
//   command channel: drive in_center_x / in_center_y (signed) with start high;
//   the word is taken at a clock edge where start is high and busy is low
//   result channel: every updated pixel comes out as one word on out_* with
//   out_valid high for exactly one cycle; out_last_of_run marks the final word
//   of a splat, and a splat that is wholly clipped gives no word at all
//   the receiver cannot stall; words are never held back for it
//   config port: cfg_we writes cfg_data into register cfg_index
//   (0 picture width, 1 picture rows, 2 large kernel); write only while idle
// timing
//   one kernel position per cycle, a read-modify-write of the level store
//   through its single read and single write port, one position behind
//   the other; the walk covers every position, zero weights and clipped ones
//   included
//   busy stays high through the scan of all N positions, N = 9 (3x3) or
//   49 (7x7), and the flush and finish states, so no new splat is taken
//   before the last one is through; the finish state sets the last word
// reset
//   a clearing pass zeroes the store, one entry a cycle, all
//   2^(clog2(MAX_COLS) + clog2(MAX_ROWS)) entries (131072 at the defaults);
//   busy is high throughout, config writes are taken as ever
module saturating_kernel_splatter_core #(
  parameter int MAX_COLS = 512,
  parameter int MAX_ROWS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [10:0] in_center_x,
  input  logic [10:0] in_center_y,
  output logic        out_valid,
  output logic [8:0]  out_pixel_col,
  output logic [7:0]  out_pixel_row,
  output logic [7:0]  out_new_level,
  output logic        out_last_of_run,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [sks_pkg::CFG_DATA_W-1:0] cfg_data
);

  sks_pkg::sks_cfg_t cfg_r, cfg_nxt;
  sks_pkg::sks_cmd_t cmd;
  sks_pkg::sks_sts_t sts;

  // config write decode, unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        sks_pkg::CFG_PICTURE_WIDTH: cfg_nxt.picture_width = cfg_data;
        sks_pkg::CFG_PICTURE_ROWS:  cfg_nxt.picture_rows  = cfg_data[8:0];
        sks_pkg::CFG_LARGE_KERNEL:  cfg_nxt.large_kernel  = cfg_data[0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.picture_width <= sks_pkg::RST_PICTURE_WIDTH;
      cfg_r.picture_rows  <= sks_pkg::RST_PICTURE_ROWS;
      cfg_r.large_kernel  <= sks_pkg::RST_LARGE_KERNEL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // sequencing: clear sweep, then one splat at a time
  sks_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .sts  (sts),
    .cmd  (cmd),
    .busy (busy)
  );

  // kernel walk, clipping, store update and word output
  sks_datapath #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg            (cfg_r),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_pixel_col  (out_pixel_col),
    .out_pixel_row  (out_pixel_row),
    .out_new_level  (out_new_level),
    .out_last_of_run(out_last_of_run)
  );

`ifndef ASSERT_OFF
  // every word comes out of a splat that was still in progress a cycle ago
  a_word_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result word without a splat in progress");

  // an accepted command keeps the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted command");

  // nothing follows the last word of a splat in the next cycle
  a_last_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_of_run) |=> !out_valid)
    else $error("word right after the last word of a splat");
`endif

endmodule

// ----- design/sks_ram.sv -----
// generic single-write, single-read ram with registered read data
module sks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/sks_ctrl.sv -----
// controller state machine: clear sweep, idle, kernel scan and wrap-up
module sks_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  sks_pkg::sks_sts_t sts,
  output sks_pkg::sks_cmd_t cmd,
  output logic              busy
);

  sks_pkg::sks_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sks_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sks_pkg::ST_CLEAR: begin
        if (sts.clear_done) state_nxt = sks_pkg::ST_IDLE;
      end
      sks_pkg::ST_IDLE: begin
        if (start) state_nxt = sks_pkg::ST_SCAN;
      end
      sks_pkg::ST_SCAN: begin
        if (sts.scan_last) state_nxt = sks_pkg::ST_FLUSH;
      end
      sks_pkg::ST_FLUSH:  state_nxt = sks_pkg::ST_FINISH;
      sks_pkg::ST_FINISH: state_nxt = sks_pkg::ST_IDLE;
      default:            state_nxt = sks_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      sks_pkg::ST_CLEAR: cmd.clear = 1'b1;
      sks_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      sks_pkg::ST_SCAN:   cmd.step = 1'b1;
      sks_pkg::ST_FLUSH:  cmd = '0;
      sks_pkg::ST_FINISH: cmd.finish = 1'b1;
      default:            cmd = '0;
    endcase
  end

endmodule

// ----- design/sks_datapath.sv -----
// datapath: kernel walk, clipping, store read-modify-write and result hold
module sks_datapath #(
  parameter int MAX_COLS = 512,
  parameter int MAX_ROWS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sks_pkg::sks_cmd_t cmd,
  input  sks_pkg::sks_cfg_t cfg,
  input  logic [10:0]       in_center_x,
  input  logic [10:0]       in_center_y,
  output sks_pkg::sks_sts_t sts,
  output logic              out_valid,
  output logic [8:0]        out_pixel_col,
  output logic [7:0]        out_pixel_row,
  output logic [7:0]        out_new_level,
  output logic              out_last_of_run
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int AW = CW + RW;
  localparam int DEPTH = 1 << AW;

  // centre and kernel walk
  logic [10:0] cx_r, cy_r;
  logic [2:0]  ky_r, ky_nxt, kx_r, kx_nxt;
  logic [2:0]  kmax;
  logic [3:0]  radius, dx_off, dy_off;
  logic [11:0] col, row;
  logic [3:0]  wgt;
  logic        col_ok, row_ok, pos_vld;
  logic [AW-1:0] rd_addr;

  // clear sweep
  logic [AW-1:0] clr_cnt_r;

  // read-modify-write stage
  logic          s1_vld_r;
  logic [AW-1:0] s1_addr_r;
  logic [3:0]    s1_wgt_r;
  logic [8:0]    s1_col_r;
  logic [7:0]    s1_row_r;
  logic [7:0]    rd_data;
  logic [8:0]    sum;
  logic [7:0]    level;

  // held word, waiting to learn whether it is the last one
  logic       pend_vld_r;
  logic [8:0] pend_col_r;
  logic [7:0] pend_row_r;
  logic [7:0] pend_lvl_r;

  logic       out_valid_r, out_last_r;
  logic [8:0] out_col_r;
  logic [7:0] out_row_r, out_lvl_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;

  assign kmax   = cfg.large_kernel ? sks_pkg::KMAX_LARGE : sks_pkg::KMAX_SMALL;
  assign radius = cfg.large_kernel ? sks_pkg::RADIUS_LARGE : sks_pkg::RADIUS_SMALL;
  assign dx_off = {1'b0, kx_r} - radius;
  assign dy_off = {1'b0, ky_r} - radius;
  assign col    = {cx_r[10], cx_r} + {{8{dx_off[3]}}, dx_off};
  assign row    = {cy_r[10], cy_r} + {{8{dy_off[3]}}, dy_off};
  assign wgt    = sks_pkg::kern_weight(cfg.large_kernel, ky_r, kx_r);

  assign col_ok = !col[11] && ({1'b0, col} < 13'(MAX_COLS))
               && ({1'b0, col[10:0]} < {2'b0, cfg.picture_width});
  assign row_ok = !row[11] && ({1'b0, row} < 13'(MAX_ROWS))
               && ({1'b0, row[10:0]} < {3'b0, cfg.picture_rows});
  assign pos_vld = col_ok && row_ok && (wgt != 4'd0);
  assign rd_addr = {col[CW-1:0], row[RW-1:0]};

  assign sts.scan_last  = (ky_r == kmax) && (kx_r == kmax);
  assign sts.clear_done = &clr_cnt_r;

  always_comb begin
    ky_nxt = ky_r;
    kx_nxt = kx_r;
    if (cmd.load) begin
      ky_nxt = 3'd0;
      kx_nxt = 3'd0;
    end else if (cmd.step) begin
      if (kx_r == kmax) begin
        kx_nxt = 3'd0;
        ky_nxt = ky_r + 3'd1;
      end else begin
        kx_nxt = kx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ky_r        <= 3'd0;
      kx_r        <= 3'd0;
      clr_cnt_r   <= '0;
      s1_vld_r    <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      ky_r     <= ky_nxt;
      kx_r     <= kx_nxt;
      if (cmd.clear) clr_cnt_r <= clr_cnt_r + 1'b1;
      s1_vld_r <= cmd.step && pos_vld;
      if (cmd.load || cmd.finish) begin
        pend_vld_r <= 1'b0;
      end else if (s1_vld_r) begin
        pend_vld_r <= 1'b1;
      end
      out_valid_r <= pend_vld_r && (s1_vld_r || cmd.finish);
      out_last_r  <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r <= in_center_x;
      cy_r <= in_center_y;
    end
    s1_addr_r <= rd_addr;
    s1_wgt_r  <= wgt;
    s1_col_r  <= col[8:0];
    s1_row_r  <= row[7:0];
    if (s1_vld_r) begin
      pend_col_r <= s1_col_r;
      pend_row_r <= s1_row_r;
      pend_lvl_r <= level;
    end
    out_col_r <= pend_col_r;
    out_row_r <= pend_row_r;
    out_lvl_r <= pend_lvl_r;
  end

  // saturating add on the word just read
  assign sum   = {1'b0, rd_data} + {5'b0, s1_wgt_r};
  assign level = sum[8] ? sks_pkg::LEVEL_MAX : sum[7:0];

  assign ram_we    = cmd.clear || s1_vld_r;
  assign ram_waddr = cmd.clear ? clr_cnt_r : s1_addr_r;
  assign ram_wdata = cmd.clear ? 8'd0 : level;

  sks_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  assign out_valid       = out_valid_r;
  assign out_pixel_col   = out_col_r;
  assign out_pixel_row   = out_row_r;
  assign out_new_level   = out_lvl_r;
  assign out_last_of_run = out_last_r;

endmodule
